// ----- rtl/core/spcs_pkg.sv -----
// ----------------------------------------------------------------------------
// spcs_pkg
// Shared types and constants of the serial port command sequencer: access
// codes, register offsets, peripheral kinds and the reply FIFO status.
// ----------------------------------------------------------------------------
package spcs_pkg;

  // Access codes carried with each input transfer
  typedef enum logic [1:0] {
    CMD_REG_RD = 2'd0,
    CMD_REG_WR = 2'd1,
    CMD_DMA_RD = 2'd2,
    CMD_DMA_WR = 2'd3
  } cmd_t;

  // Selected peripheral
  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_CTRL = 2'd1,
    KIND_CARD = 2'd2
  } kind_t;

  // Reply FIFO status toward the sequencer
  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

  // Register map
  localparam logic [7:0] PARAM_END  = 8'h40;  // param table below this
  localparam logic [7:0] OFF_CMD    = 8'h60;
  localparam logic [7:0] OFF_REPLY  = 8'h64;
  localparam logic [7:0] OFF_CTRL   = 8'h68;
  localparam logic [7:0] OFF_STAT   = 8'h6C;
  localparam logic [7:0] OFF_MODE   = 8'h70;

  localparam logic [31:0] STAT_WORD = 32'h0001_D100;
  localparam logic [31:0] MODE_WORD = 32'h0000_000F;

  // Peripheral select bytes and stub replies
  localparam logic [7:0] SEL_NONE   = 8'h00;
  localparam logic [7:0] SEL_CTRL   = 8'h01;
  localparam logic [7:0] SEL_CARD   = 8'h81;
  localparam logic [7:0] REPLY_CTRL = 8'h00;
  localparam logic [7:0] REPLY_CARD = 8'hFF;

  // Parameter table and length field
  localparam int unsigned PARAM_ENTRIES = 16;
  localparam int unsigned PIDX_W        = 4;
  localparam int unsigned LEN_LSB       = 18;
  localparam int unsigned LEN_W         = 7;

  localparam int unsigned FIFO_DEPTH_DEF = 64;

endpackage

// ----- rtl/core/serial_port_command_sequencer_top.sv -----
// ----------------------------------------------------------------------------
// serial_port_command_sequencer_top
// Register and DMA front end of a serial port: parameter table, control
// register, command byte sequencing and the reply byte FIFO.
// ----------------------------------------------------------------------------
// One access per transfer, one transfer per clock. Each accepted access
// produces exactly one result transfer in the next cycle from an output
// register; a new access is taken in the same cycle the previous result
// leaves, so the rate is one per cycle as long as out_tready stays high.
// The parameter table (16 words, valid bit per entry so it reads zero
// after reset) and the reply FIFO sit in synchronous memories whose next
// entry is prefetched each cycle, with bypass when the access being
// processed writes that entry. No clearing pass is needed after reset.
// Send table writes are accepted and discarded, as nothing reads them.
// ----------------------------------------------------------------------------
module serial_port_command_sequencer_top #(
  parameter int unsigned FIFO_DEPTH = spcs_pkg::FIFO_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [7:0] offset, [39:8] write_data
  input  logic [1:0]  in_tuser,   // [1:0] cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] read_data
  output logic [1:0]  out_tuser   // [0] irq_request, [1] fifo_underflow
);
  import spcs_pkg::*;

  // Input decode
  cmd_t        cmd;
  logic [7:0]  offset;
  logic [31:0] wdata;
  logic        in_fire;

  assign cmd     = cmd_t'(in_tuser);
  assign offset  = in_tdata[7:0];
  assign wdata   = in_tdata[39:8];
  assign in_fire = in_tvalid && in_tready;

  // Architectural state
  logic [31:0]       ctrl_r, ctrl_nxt;
  logic [LEN_W-1:0]  bytes_left_r, bytes_left_nxt;
  logic [PIDX_W-1:0] tidx_r, tidx_nxt;
  kind_t             kind_r, kind_nxt;

  // Parameter table memory and prefetch
  logic [31:0]              param_mem [PARAM_ENTRIES];
  logic [PARAM_ENTRIES-1:0] pvalid_r, pvalid_nxt;
  logic [31:0]              pword_r;
  logic                     pword_ok_r;
  logic                     pwe;
  logic [PIDX_W-1:0]        pwaddr;
  logic [31:0]              pword;

  // Reply FIFO
  logic       push, pop;
  logic [7:0] push_data;
  logic [7:0] head_data;
  fifo_stat_t fst;

  // Command byte datapath
  logic             cbyte_go;
  logic [7:0]       cbyte;
  logic             start;
  kind_t            kind_sel;
  logic [LEN_W-1:0] len;

  // Result
  logic [31:0] rd;
  logic        irq, under;
  logic        out_valid_r;
  logic [31:0] out_data_r;
  logic        out_irq_r, out_under_r;

  assign in_tready  = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = {out_under_r, out_irq_r};

  assign pword  = pword_ok_r ? pword_r : '0;
  assign pwaddr = offset[PIDX_W+1:2];
  assign cbyte  = wdata[7:0];
  assign start  = (bytes_left_r == '0);

  // Peripheral select from command byte
  always_comb begin
    case (cbyte)
      SEL_NONE: kind_sel = KIND_NONE;
      SEL_CTRL: kind_sel = KIND_CTRL;
      SEL_CARD: kind_sel = KIND_CARD;
      default:  kind_sel = kind_r;
    endcase
  end

  assign len = start ? pword[LEN_LSB+LEN_W-1:LEN_LSB] : bytes_left_r;

  // Access decode and state update
  always_comb begin
    rd             = '0;
    irq            = 1'b0;
    under          = 1'b0;
    ctrl_nxt       = ctrl_r;
    bytes_left_nxt = bytes_left_r;
    tidx_nxt       = tidx_r;
    kind_nxt       = kind_r;
    pwe            = 1'b0;
    push           = 1'b0;
    push_data      = REPLY_CTRL;
    pop            = 1'b0;
    cbyte_go       = 1'b0;
    if (in_fire) begin
      case (cmd)
        CMD_REG_RD: begin
          case (offset)
            OFF_REPLY: pop = 1'b1;
            OFF_CTRL:  rd  = ctrl_r;
            OFF_STAT:  rd  = STAT_WORD;
            OFF_MODE:  rd  = MODE_WORD;
            default:   rd  = '0;
          endcase
        end
        CMD_REG_WR: begin
          if (offset < PARAM_END) begin
            pwe = 1'b1;
          end else if (offset == OFF_CMD) begin
            cbyte_go = 1'b1;
          end else if (offset == OFF_CTRL) begin
            ctrl_nxt = {wdata[31:1], 1'b0};
            irq      = wdata[0];
            if (wdata[2] || wdata[3]) begin
              bytes_left_nxt = '0;
              tidx_nxt       = '0;
              kind_nxt       = KIND_NONE;
            end
          end
        end
        CMD_DMA_RD: pop = 1'b1;
        CMD_DMA_WR: cbyte_go = 1'b1;
        default:    rd = '0;
      endcase
    end

    // Reply pop
    if (pop) begin
      if (fst.empty) begin
        under = 1'b1;
      end else begin
        rd = {24'b0, head_data};
      end
    end

    // Command byte: new transfer setup, length countdown, stub reply
    if (cbyte_go) begin
      if (start) begin
        kind_nxt = kind_sel;
        tidx_nxt = tidx_r + 1'b1;
      end
      bytes_left_nxt = (len != '0) ? len - 1'b1 : '0;
      if (kind_nxt == KIND_CTRL) begin
        push      = 1'b1;
        push_data = REPLY_CTRL;
      end else if (kind_nxt == KIND_CARD) begin
        push      = 1'b1;
        push_data = REPLY_CARD;
      end
    end
  end

  assign pvalid_nxt = pwe ?
    (pvalid_r | ({{(PARAM_ENTRIES-1){1'b0}}, 1'b1} << pwaddr)) : pvalid_r;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r       <= '0;
      bytes_left_r <= '0;
      tidx_r       <= '0;
      kind_r       <= KIND_NONE;
      pvalid_r     <= '0;
      pword_ok_r   <= 1'b0;
    end else begin
      ctrl_r       <= ctrl_nxt;
      bytes_left_r <= bytes_left_nxt;
      tidx_r       <= tidx_nxt;
      kind_r       <= kind_nxt;
      pvalid_r     <= pvalid_nxt;
      pword_ok_r   <= pvalid_nxt[tidx_nxt];
    end
  end

  // Parameter table write and prefetch of the next entry
  always_ff @(posedge clk) begin
    if (pwe) begin
      param_mem[pwaddr] <= wdata;
    end
    if (pwe && (pwaddr == tidx_nxt)) begin
      pword_r <= wdata;
    end else begin
      pword_r <= param_mem[tidx_nxt];
    end
  end

  spcs_reply_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_reply_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head_data (head_data),
    .stat      (fst)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r  <= rd;
      out_irq_r   <= irq;
      out_under_r <= under;
    end
  end

`ifndef SYNTHESIS
  // FIFO can never look empty and full at once
  a_fifo_stat: assert property (@(posedge clk) disable iff (!rst_n)
    !(fst.empty && fst.full))
    else $error("reply FIFO status both empty and full");

  // Control write with a reset bit clears the transfer state
  a_ctrl_reset: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (cmd == CMD_REG_WR) && (offset == OFF_CTRL) && (wdata[2] || wdata[3]))
    |=> (bytes_left_r == '0) && (tidx_r == '0) && (kind_r == KIND_NONE))
    else $error("transfer state not cleared by control write");

  // An underflow result carries zero data
  a_under_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_under_r) |-> (out_data_r == '0))
    else $error("underflow result with nonzero data");
`endif

endmodule

// ----- rtl/core/spcs_reply_fifo.sv -----
// ----------------------------------------------------------------------------
// spcs_reply_fifo
// Reply byte FIFO in a synchronous memory. The head entry is prefetched into
// a register so a pop sees its byte in the same cycle; a push into a full
// FIFO is dropped.
// ----------------------------------------------------------------------------
module spcs_reply_fifo #(
  parameter int unsigned DEPTH = spcs_pkg::FIFO_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  logic [7:0]           push_data,
  input  logic                 pop,
  output logic [7:0]           head_data,
  output spcs_pkg::fifo_stat_t stat
);
  import spcs_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [7:0]       mem [DEPTH];
  logic [PTR_W-1:0] head_r, head_nxt;
  logic [PTR_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [7:0]       head_data_r;
  logic             do_push, do_pop;

  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == CNT_FULL);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head_data  = head_data_r;

  // Pointer and count update
  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (do_pop) begin
      head_nxt = (head_r == PTR_LAST) ? '0 : head_r + 1'b1;
    end
    if (do_push) begin
      tail_nxt = (tail_r == PTR_LAST) ? '0 : tail_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  // Storage write, head prefetch with bypass of a same-entry write
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[tail_r] <= push_data;
    end
    if (do_push && (tail_r == head_nxt)) begin
      head_data_r <= push_data;
    end else begin
      head_data_r <= mem[head_nxt];
    end
  end

endmodule
